@@ rtl/indexed_min_heap_queue_macros.svh @@
// Assertion macros used by the checker file.
`ifndef INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IMHQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imhq assertion failed");

// Next-cycle implication, checked outside reset.
`define IMHQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imhq assertion failed");

`endif

@@ rtl/imhq_pkg.sv @@
package imhq_pkg;

    // Default sizes.
    localparam int DEF_HEAP_CAPACITY = 1024;
    localparam int DEF_ITEM_COUNT    = 1024;
    localparam int DEF_KEY_BITS      = 32;

    // Fixed port field widths.
    localparam int ID_W     = 10;
    localparam int KEYIN_W  = 32;
    localparam int ACT_W    = 2;
    localparam int STAT_W   = 3;
    localparam int OCC_W    = 11;

    // Request codes.
    localparam logic [ACT_W-1:0] ACT_INSERT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_POP      = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DECREASE = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] STAT_DUP       = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ABSENT    = 3'd4;
    localparam logic [STAT_W-1:0] STAT_NOT_LOWER = 3'd5;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_POS_WAIT,
        S_DEC_CHK,
        S_UP_RD,
        S_UP_CMP,
        S_PLACE,
        S_POP_TOP,
        S_POP_LAST,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

@@ rtl/indexed_min_heap_queue.sv @@
// Insert and decrease-key sift the item up from its slot (S_UP_RD, S_UP_CMP per level), and pop
// moves the last item to the root and sifts it down (S_DN_L, S_DN_R, S_DN_CMP per level); a pop
// when empty, an unused action and a rejected insert or decrease-key skip the heap walk, and a
// pop of the only item ends after removing it. The result waits in S_DONE while the output stalls.
// Throughput: one transaction at a time; the next is taken the cycle after a result is loaded.
// Reset: asynchronous, active low; empties the queue, then clears the item table before accepting requests.
module indexed_min_heap_queue #(
    parameter int HEAP_CAPACITY = imhq_pkg::DEF_HEAP_CAPACITY,
    parameter int ITEM_COUNT    = imhq_pkg::DEF_ITEM_COUNT,
    parameter int KEY_BITS      = imhq_pkg::DEF_KEY_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [imhq_pkg::ACT_W-1:0]    action,
    input  logic [imhq_pkg::ID_W-1:0]     item_id,
    input  logic [imhq_pkg::KEYIN_W-1:0]  key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [imhq_pkg::STAT_W-1:0]   status,
    output logic [imhq_pkg::ID_W-1:0]     popped_item,
    output logic [imhq_pkg::KEYIN_W-1:0]  popped_key,
    output logic [imhq_pkg::OCC_W-1:0]    occupancy
);
    import imhq_pkg::*;

    localparam int AW = $clog2(HEAP_CAPACITY);
    localparam int CW = $clog2(HEAP_CAPACITY + 1);
    localparam int IW = $clog2(ITEM_COUNT);
    localparam int HW = ID_W + KEY_BITS;
    localparam logic [CW-1:0] NOT_QUEUED = CW'(HEAP_CAPACITY);
    localparam logic [CW-1:0] CAP_C      = CW'(HEAP_CAPACITY);
    localparam logic [IW-1:0] LAST_ITEM  = IW'(ITEM_COUNT - 1);

    // Memories: heap slots hold {item, key}, position table holds a slot index.
    logic [HW-1:0] heap_mem [HEAP_CAPACITY];
    logic [CW-1:0] pos_mem  [ITEM_COUNT];
    logic [HW-1:0] heap_rd_reg;
    logic [CW-1:0] pos_rd_reg;

    logic          heap_we;
    logic [AW-1:0] heap_waddr, heap_raddr;
    logic [HW-1:0] heap_wdata;
    logic          pos_we;
    logic [IW-1:0] pos_waddr, pos_raddr;
    logic [CW-1:0] pos_wdata;

    state_t state_reg, state_next;
    logic [ACT_W-1:0]    act_reg, act_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [ID_W-1:0]     mv_item_reg, mv_item_next;
    logic [KEY_BITS-1:0] mv_key_reg, mv_key_next;
    logic [CW-1:0]       hole_reg, hole_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [ID_W-1:0]     left_item_reg, left_item_next;
    logic [KEY_BITS-1:0] left_key_reg, left_key_next;
    logic                has_r_reg, has_r_next;
    logic [STAT_W-1:0]   st_reg, st_next;
    logic [ID_W-1:0]     pitem_reg, pitem_next;
    logic [KEY_BITS-1:0] pkey_reg, pkey_next;
    logic [IW-1:0]       clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   out_status_reg, out_status_next;
    logic [ID_W-1:0]     out_item_reg, out_item_next;
    logic [KEYIN_W-1:0]  out_key_reg, out_key_next;
    logic [OCC_W-1:0]    out_occ_reg, out_occ_next;

    // Decoded fields and address arithmetic.
    logic [ID_W-1:0]     rd_item;
    logic [KEY_BITS-1:0] rd_key;
    logic                accept, id_ok, pos_in_heap, out_free;
    logic [CW:0]         left_idx, right_idx;
    logic [CW-1:0]       parent_idx, count_dec;
    logic                has_l, has_r, up_move, dn_stop, pick_r;

    assign rd_item     = heap_rd_reg[KEY_BITS +: ID_W];
    assign rd_key      = heap_rd_reg[KEY_BITS-1:0];
    assign accept      = in_valid && !in_stall;
    assign id_ok       = 32'(id_reg) < 32'(ITEM_COUNT);
    assign pos_in_heap = pos_rd_reg < count_reg;
    assign out_free    = !out_valid_reg || !out_stall;
    assign left_idx    = {hole_reg, 1'b1};
    assign right_idx   = {hole_reg, 1'b0} + (CW+1)'(2);
    assign parent_idx  = (hole_reg - CW'(1)) >> 1;
    assign count_dec   = count_reg - CW'(1);
    assign has_l       = left_idx < {1'b0, count_reg};
    assign has_r       = right_idx < {1'b0, count_reg};
    assign up_move     = rd_key > mv_key_reg;
    assign dn_stop     = (mv_key_reg <= left_key_reg) && (!has_r_reg || mv_key_reg <= rd_key);
    assign pick_r      = has_r_reg && (rd_key <= left_key_reg);

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign popped_item = out_item_reg;
    assign popped_key  = out_key_reg;
    assign occupancy   = out_occ_reg;

    // Memory ports: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rd_reg <= heap_mem[heap_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:    if (clr_reg == LAST_ITEM) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_POP)
                        state_next = (count_reg == '0) ? S_DONE : S_POP_TOP;
                    else if (action == ACT_INSERT || action == ACT_DECREASE)
                        state_next = S_POS_WAIT;
                    else
                        state_next = S_DONE;
                end
            end
            S_POS_WAIT:
            begin
                if (!id_ok)
                    state_next = S_DONE;
                else if (act_reg == ACT_INSERT)
                    state_next = (pos_in_heap || count_reg >= CAP_C) ? S_DONE : S_UP_RD;
                else
                    state_next = pos_in_heap ? S_DEC_CHK : S_DONE;
            end
            S_DEC_CHK:  state_next = (key_reg < rd_key) ? S_UP_RD : S_DONE;
            S_UP_RD:    state_next = (hole_reg == '0) ? S_PLACE : S_UP_CMP;
            S_UP_CMP:   state_next = up_move ? S_UP_RD : S_PLACE;
            S_PLACE:    state_next = S_DONE;
            S_POP_TOP:  state_next = (count_dec == '0) ? S_DONE : S_POP_LAST;
            S_POP_LAST: state_next = S_DN_L;
            S_DN_L:     state_next = has_l ? S_DN_R : S_PLACE;
            S_DN_R:     state_next = S_DN_CMP;
            S_DN_CMP:   state_next = dn_stop ? S_PLACE : S_DN_L;
            S_DONE:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath registers and memory controls.
    always_comb
    begin
        act_next        = act_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        mv_item_next    = mv_item_reg;
        mv_key_next     = mv_key_reg;
        hole_next       = hole_reg;
        count_next      = count_reg;
        left_item_next  = left_item_reg;
        left_key_next   = left_key_reg;
        has_r_next      = has_r_reg;
        st_next         = st_reg;
        pitem_next      = pitem_reg;
        pkey_next       = pkey_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_item_next   = out_item_reg;
        out_key_next    = out_key_reg;
        out_occ_next    = out_occ_reg;
        heap_we    = 1'b0;
        heap_waddr = hole_reg[AW-1:0];
        heap_wdata = {mv_item_reg, mv_key_reg};
        heap_raddr = '0;
        pos_we     = 1'b0;
        pos_waddr  = IW'(mv_item_reg);
        pos_wdata  = hole_reg;
        pos_raddr  = IW'(item_id);
        case (state_reg)
            S_CLEAR:
            begin
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = NOT_QUEUED;
                clr_next  = clr_reg + IW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action;
                    id_next    = item_id;
                    key_next   = KEY_BITS'(key);
                    pitem_next = '0;
                    pkey_next  = '0;
                    st_next    = (action == ACT_POP && count_reg == '0) ? STAT_EMPTY : STAT_OK;
                end
            end
            S_POS_WAIT:
            begin
                heap_raddr   = pos_rd_reg[AW-1:0];
                mv_item_next = id_reg;
                mv_key_next  = key_reg;
                if (!id_ok)
                    st_next = STAT_ABSENT;
                else if (act_reg == ACT_INSERT)
                begin
                    if (pos_in_heap)
                        st_next = STAT_DUP;
                    else if (count_reg >= CAP_C)
                        st_next = STAT_FULL;
                    else
                    begin
                        hole_next  = count_reg;
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (!pos_in_heap)
                    st_next = STAT_ABSENT;
                else
                    hole_next = pos_rd_reg;
            end
            S_DEC_CHK:
            begin
                if (!(key_reg < rd_key))
                    st_next = STAT_NOT_LOWER;
            end
            S_UP_RD:
            begin
                heap_raddr = parent_idx[AW-1:0];
            end
            S_UP_CMP:
            begin
                // Parent moves down into the hole.
                if (up_move)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rd_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = IW'(rd_item);
                    hole_next  = parent_idx;
                end
            end
            S_PLACE:
            begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            S_POP_TOP:
            begin
                heap_raddr = count_dec[AW-1:0];
                pitem_next = rd_item;
                pkey_next  = rd_key;
                count_next = count_dec;
                pos_we     = 1'b1;
                pos_waddr  = IW'(rd_item);
                pos_wdata  = NOT_QUEUED;
            end
            S_POP_LAST:
            begin
                mv_item_next = rd_item;
                mv_key_next  = rd_key;
                hole_next    = '0;
            end
            S_DN_L:
            begin
                heap_raddr = left_idx[AW-1:0];
            end
            S_DN_R:
            begin
                heap_raddr     = right_idx[AW-1:0];
                left_item_next = rd_item;
                left_key_next  = rd_key;
                has_r_next     = has_r;
            end
            S_DN_CMP:
            begin
                // Smaller child moves up into the hole.
                if (!dn_stop)
                begin
                    heap_we   = 1'b1;
                    pos_we    = 1'b1;
                    if (pick_r)
                    begin
                        heap_wdata = heap_rd_reg;
                        pos_waddr  = IW'(rd_item);
                        hole_next  = right_idx[CW-1:0];
                    end
                    else
                    begin
                        heap_wdata = {left_item_reg, left_key_reg};
                        pos_waddr  = IW'(left_item_reg);
                        hole_next  = left_idx[CW-1:0];
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = st_reg;
                    out_item_next   = pitem_reg;
                    out_key_next    = KEYIN_W'(pkey_reg);
                    out_occ_next    = OCC_W'(count_reg);
                end
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            count_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        id_reg         <= id_next;
        key_reg        <= key_next;
        mv_item_reg    <= mv_item_next;
        mv_key_reg     <= mv_key_next;
        hole_reg       <= hole_next;
        left_item_reg  <= left_item_next;
        left_key_reg   <= left_key_next;
        has_r_reg      <= has_r_next;
        st_reg         <= st_next;
        pitem_reg      <= pitem_next;
        pkey_reg       <= pkey_next;
        out_status_reg <= out_status_next;
        out_item_reg   <= out_item_next;
        out_key_reg    <= out_key_next;
        out_occ_reg    <= out_occ_next;
    end

endmodule

@@ rtl/imhq_checker.sv @@
`include "indexed_min_heap_queue_macros.svh"

module imhq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [imhq_pkg::STAT_W-1:0]   status,
    input logic [imhq_pkg::ID_W-1:0]     popped_item,
    input logic [imhq_pkg::KEYIN_W-1:0]  popped_key,
    input logic [imhq_pkg::OCC_W-1:0]    occupancy
);
    import imhq_pkg::*;

    // A stalled result holds its status.
    `IMHQ_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(status))

    // Only a successful pop reports an item.
    `IMHQ_ASSERT_NOW(a_pop_zero, out_valid && status != STAT_OK, popped_item == '0 && popped_key == '0)

    // An empty result means the queue holds nothing.
    `IMHQ_ASSERT_NOW(a_empty_occ, out_valid && status == STAT_EMPTY, occupancy == '0)

    // Status codes stay within the defined set.
    `IMHQ_ASSERT_NOW(a_status_range, out_valid, status <= STAT_NOT_LOWER)

endmodule

bind indexed_min_heap_queue imhq_checker u_imhq_checker (.*);
